// File: rtl/ntis_pkg.sv
// Shared types and constants for the nearest time index search unit.
package ntis_pkg;

  localparam int TIME_W            = 48;
  localparam int ROW_W             = 12;
  localparam int TABLE_DEPTH_DEF   = 4096;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic                     mode;
    logic signed [TIME_W-1:0] time_value;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0] row_index;
    logic             overflowed;
  } out_item_t;

  // Result of one pass through the shared subtractor.
  typedef struct packed {
    logic eq;
    logic lt;
  } cmp_flags_t;

endpackage

// File: rtl/ntis_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ntis_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/ntis_cmp_unit.sv
// Shared 49-bit subtractor: signed compare of query time against a table entry.
module ntis_cmp_unit
  import ntis_pkg::*;
(
  input  logic signed [TIME_W-1:0] a,
  input  logic signed [TIME_W-1:0] b,
  output logic signed [TIME_W:0]   diff,
  output cmp_flags_t               flags
);

  assign diff     = {a[TIME_W-1], a} - {b[TIME_W-1], b};
  assign flags.eq = (diff == '0);
  assign flags.lt = diff[TIME_W];

endmodule

// File: rtl/nearest_time_index_search_unit.sv
// Nearest time index search: a load (mode 0) appends a Q24.24 timestamp to the table and gives
// no result; a load into a full table is dropped and sets the sticky overflow flag. A query
// (mode 1) binary-searches the stored entries, each probe a RAM read and then a compare in the
// shared subtractor, with at most log2(TABLE_DEPTH) probes plus a check that finds the range
// closed, then steps through each of the two or three neighbors around the final position
// (subtract, then distance compare) and hands over the result from S_EMIT. The search ends
// early on an exact match or a table of one entry or none. The single RAM read port and the
// one subtractor set the pace of these steps.
// The input is stalled while a query is in progress and while its result waits behind a stalled
// output; a finished result sits in an output register.
module nearest_time_index_search_unit
  import ntis_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int SW = IW + 2;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_CHECK    = 6'b000010,
    S_MID      = 6'b000100,
    S_NEAR_SUB = 6'b001000,
    S_NEAR_CMP = 6'b010000,
    S_EMIT     = 6'b100000
  } state_t;

  state_t state;

  logic [IW:0]              cnt;
  logic                     ovf;
  logic signed [SW-1:0]     lo;
  logic signed [SW-1:0]     hi;
  logic [IW-1:0]            mid_q;
  logic [IW-1:0]            near_idx;
  logic [IW-1:0]            end_idx;
  logic [IW-1:0]            best_idx;
  logic [IW-1:0]            res_idx;
  logic [TIME_W:0]          best_d;
  logic                     first;
  logic signed [TIME_W-1:0] tq;
  logic signed [TIME_W:0]   diff_q;

  logic signed [SW-1:0]     cnt_ext;
  logic signed [SW-1:0]     sum;
  logic [IW-1:0]            mid_c;
  logic signed [SW-1:0]     hi_m1;
  logic signed [SW-1:0]     hi_p1;
  logic signed [SW-1:0]     mid_ext;
  logic                     has_next;
  logic                     full;
  logic                     in_acc;
  logic                     we;
  logic                     out_load;
  logic                     take;
  logic [TIME_W:0]          mag;
  logic [IW-1:0]            raddr;
  logic [TIME_W-1:0]        rdata;
  logic signed [TIME_W:0]   diff;
  cmp_flags_t               flags;

  assign cnt_ext  = signed'({1'b0, cnt});
  assign sum      = lo + hi;
  assign mid_c    = sum[IW:1];
  assign hi_m1    = hi - SW'(1);
  assign hi_p1    = hi + SW'(1);
  assign mid_ext  = signed'({2'b00, mid_q});
  assign has_next = (hi_p1 < cnt_ext);
  assign full     = (cnt == (IW+1)'(TABLE_DEPTH));
  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && (state == S_IDLE);
  assign we       = in_acc && (in_item.mode == MODE_LOAD) && !full;
  assign out_load = (state == S_EMIT) && (!out_valid || !out_stall);
  assign mag      = diff_q[TIME_W] ? unsigned'(-diff_q) : unsigned'(diff_q);
  assign take     = first || (mag <= best_d);

  always_comb begin
    unique case (state)
      S_CHECK:    raddr = (lo >= hi) ? hi_m1[IW-1:0] : mid_c;
      S_NEAR_CMP: raddr = near_idx + IW'(1);
      default:    raddr = mid_c;
    endcase
  end

  ntis_ram #(
    .WIDTH (TIME_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (cnt[IW-1:0]),
    .wdata (in_item.time_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  ntis_cmp_unit u_cmp (
    .a     (tq),
    .b     (signed'(rdata)),
    .diff  (diff),
    .flags (flags)
  );

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (in_item.mode == MODE_QUERY) begin
              state <= S_CHECK;
            end else if (full) begin
              ovf <= 1'b1;
            end else begin
              cnt <= cnt + (IW+1)'(1);
            end
          end
        end
        S_CHECK: begin
          if (hi <= 0) begin
            state <= S_EMIT;
          end else if (lo >= hi) begin
            state <= S_NEAR_SUB;
          end else begin
            state <= S_MID;
          end
        end
        S_MID: begin
          state <= flags.eq ? S_EMIT : S_CHECK;
        end
        S_NEAR_SUB: begin
          state <= S_NEAR_CMP;
        end
        S_NEAR_CMP: begin
          state <= (near_idx == end_idx) ? S_EMIT : S_NEAR_SUB;
        end
        S_EMIT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          tq <= in_item.time_value;
          lo <= '0;
          hi <= cnt_ext - SW'(1);
        end
      end
      S_CHECK: begin
        mid_q    <= mid_c;
        near_idx <= hi_m1[IW-1:0];
        end_idx  <= has_next ? hi_p1[IW-1:0] : hi[IW-1:0];
        first    <= 1'b1;
        res_idx  <= '0;
      end
      S_MID: begin
        res_idx <= mid_q;
        if (flags.lt) begin
          hi <= mid_ext - SW'(1);
        end else begin
          lo <= mid_ext + SW'(1);
        end
      end
      S_NEAR_SUB: begin
        diff_q <= diff;
      end
      S_NEAR_CMP: begin
        // Later neighbor wins a tie.
        if (take) begin
          best_d   <= mag;
          best_idx <= near_idx;
        end
        res_idx  <= take ? near_idx : best_idx;
        first    <= 1'b0;
        near_idx <= near_idx + IW'(1);
      end
      S_EMIT: begin
        if (out_load) begin
          out_item.row_index  <= ROW_W'(res_idx);
          out_item.overflowed <= ovf;
        end
      end
      default: ;
    endcase
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= (IW+1)'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst)
    ovf |=> ovf)
    else $error("overflow flag cleared without reset");

  a_hi_in_table: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> (hi < cnt_ext))
    else $error("search bound outside stored entries");

  a_near_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_NEAR_SUB) |-> (near_idx <= end_idx))
    else $error("neighbor scan ran past its end");

  a_mid_follows_check: assert property (@(posedge clk) disable iff (rst)
    (state == S_MID) |-> $past(state == S_CHECK))
    else $error("probe compare without preceding read");

endmodule
